### hw/rtl/skt_pkg.sv
// Shared widths, codes and cell control types for the sorted key table.
package skt_pkg;

    localparam int KEY_W       = 16;
    localparam int LABEL_WIDTH = 64;
    localparam int AMT_W       = 32;
    localparam int CMD_W       = 3;
    localparam int STATUS_W    = 2;
    localparam int ENTRIES_W   = 7;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_UPDATE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DUMP   = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    localparam logic signed [AMT_W-1:0] AMT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [AMT_W-1:0] AMT_MIN = 32'sh8000_0000;

    // Operation broadcast to every cell of the chain
    typedef enum logic [2:0] {
        OP_NONE,
        OP_INSERT,
        OP_DELETE,
        OP_UPDATE,
        OP_ROTATE
    } tbl_op_t;

    typedef struct packed {
        tbl_op_t op;
        logic    capture;
    } cell_ctrl_t;

endpackage

### hw/rtl/skt_if.sv
// Request and response channel interfaces of the sorted key table.
interface skt_req_if import skt_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        cmd;
    logic [KEY_W-1:0]        key;
    logic [LABEL_WIDTH-1:0]  label;
    logic signed [AMT_W-1:0] amount;

    modport source (output valid, cmd, key, label, amount, input ready);
    modport sink   (input valid, cmd, key, label, amount, output ready);
endinterface

interface skt_rsp_if import skt_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [STATUS_W-1:0]     status;
    logic [KEY_W-1:0]        out_key;
    logic [LABEL_WIDTH-1:0]  out_label;
    logic signed [AMT_W-1:0] out_amount;
    logic [ENTRIES_W-1:0]    entries;
    logic                    last;

    modport source (output valid, status, out_key, out_label, out_amount, entries, last,
                    input ready);
    modport sink   (input valid, status, out_key, out_label, out_amount, entries, last,
                    output ready);
endinterface

### hw/rtl/skt_cell.sv
// One table slot: holds an entry, compares it with the request key, shifts with neighbors.
module skt_cell import skt_pkg::*; #(
    parameter int LABEL_W = 64
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  cell_ctrl_t              ctrl,
    input  logic [KEY_W-1:0]        cmp_key,
    input  logic                    occ,
    input  logic                    tail,
    input  logic                    prev_less,
    input  logic [KEY_W-1:0]        new_key,
    input  logic [LABEL_W-1:0]      new_label,
    input  logic signed [AMT_W-1:0] new_amount,
    input  logic [KEY_W-1:0]        prev_key,
    input  logic [LABEL_W-1:0]      prev_label,
    input  logic signed [AMT_W-1:0] prev_amount,
    input  logic [KEY_W-1:0]        next_key,
    input  logic [LABEL_W-1:0]      next_label,
    input  logic signed [AMT_W-1:0] next_amount,
    input  logic [KEY_W-1:0]        head_key,
    input  logic [LABEL_W-1:0]      head_label,
    input  logic signed [AMT_W-1:0] head_amount,
    output logic [KEY_W-1:0]        key,
    output logic [LABEL_W-1:0]      label,
    output logic signed [AMT_W-1:0] amount,
    output logic                    match,
    output logic                    less
);

    logic [KEY_W-1:0]        key_reg,    key_next;
    logic [LABEL_W-1:0]      label_reg,  label_next;
    logic signed [AMT_W-1:0] amount_reg, amount_next;
    logic                    match_reg,  match_next;
    logic                    less_reg,   less_next;

    // Compare the held key against the incoming request key
    always_comb
    begin
        match_next = match_reg;
        less_next  = less_reg;
        if (ctrl.capture)
        begin
            match_next = occ && (key_reg == cmp_key);
            less_next  = occ && (key_reg < cmp_key);
        end
    end

    // Select where the entry comes from for this cycle
    always_comb
    begin
        key_next    = key_reg;
        label_next  = label_reg;
        amount_next = amount_reg;
        unique case (ctrl.op)
            OP_INSERT:
            begin
                // First slot at or above the new key takes it, the rest move up
                if (!less_reg)
                begin
                    if (prev_less)
                    begin
                        key_next    = new_key;
                        label_next  = new_label;
                        amount_next = new_amount;
                    end
                    else
                    begin
                        key_next    = prev_key;
                        label_next  = prev_label;
                        amount_next = prev_amount;
                    end
                end
            end
            OP_DELETE:
            begin
                // Slots at or above the removed key move down
                if (!less_reg)
                begin
                    key_next    = next_key;
                    label_next  = next_label;
                    amount_next = next_amount;
                end
            end
            OP_UPDATE:
            begin
                if (match_reg)
                begin
                    label_next  = new_label;
                    amount_next = new_amount;
                end
            end
            OP_ROTATE:
            begin
                // Rotate occupied slots down by one, head wraps to the tail
                if (occ)
                begin
                    if (tail)
                    begin
                        key_next    = head_key;
                        label_next  = head_label;
                        amount_next = head_amount;
                    end
                    else
                    begin
                        key_next    = next_key;
                        label_next  = next_label;
                        amount_next = next_amount;
                    end
                end
            end
            default:
            begin
                key_next = key_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
            less_reg  <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
            less_reg  <= less_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        label_reg  <= label_next;
        amount_reg <= amount_next;
    end

    assign key    = key_reg;
    assign label  = label_reg;
    assign amount = amount_reg;
    assign match  = match_reg;
    assign less   = less_reg;

endmodule

### hw/rtl/sorted_key_table.sv
// Sorted key table top level: control sequencer over a chain of entry cells.
//
// Holds up to DEPTH entries (key, LABEL_BYTES-byte name, signed quantity) in
// ascending key order, one entry per cell. Every cell compares its key with the
// request key in the cycle the request is accepted, so insert, delete, update,
// search and undefined commands then need only the execute state, in which
// the whole chain shifts up or down at once and the result is loaded into the
// output register. In a dump the chain rotates through cell 0, one entry per
// cycle while the result register is free, until it is back in order.
// The result register lets the block accept the next request while a result
// waits; execution stalls only while an earlier result has not been taken.
// The table is empty after reset with no clearing pass.
module sorted_key_table import skt_pkg::*; #(
    parameter int DEPTH       = 64,
    parameter int LABEL_BYTES = 8
) (
    input  logic clk,
    input  logic rst_n,
    skt_req_if.sink   req,
    skt_rsp_if.source rsp
);

    localparam int LABEL_W = 8 * LABEL_BYTES;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int IDX_W   = $clog2(DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DUMP
    } state_t;

    state_t                  state_reg,       state_next;
    logic [CMD_W-1:0]        cmd_reg,         cmd_next;
    logic [KEY_W-1:0]        key_reg,         key_next;
    logic [LABEL_W-1:0]      label_reg,       label_next;
    logic signed [AMT_W-1:0] amount_reg,      amount_next;
    logic [CNT_W-1:0]        count_reg,       count_next;
    logic [IDX_W-1:0]        dump_idx_reg,    dump_idx_next;

    logic                    out_valid_reg,   out_valid_next;
    logic [STATUS_W-1:0]     out_status_reg,  out_status_next;
    logic [KEY_W-1:0]        out_key_reg,     out_key_next;
    logic [LABEL_W-1:0]      out_label_reg,   out_label_next;
    logic signed [AMT_W-1:0] out_amount_reg,  out_amount_next;
    logic [ENTRIES_W-1:0]    out_entries_reg, out_entries_next;
    logic                    out_last_reg,    out_last_next;

    logic [KEY_W-1:0]        cell_key    [DEPTH];
    logic [LABEL_W-1:0]      cell_label  [DEPTH];
    logic signed [AMT_W-1:0] cell_amount [DEPTH];
    logic [DEPTH-1:0]        match_vec;
    logic [DEPTH-1:0]        less_vec;

    cell_ctrl_t              ctrl;
    logic                    accept;
    logic                    out_free;
    logic                    found;
    logic                    full;
    logic                    dump_last;
    logic [KEY_W-1:0]        sel_key;
    logic [LABEL_W-1:0]      sel_label;
    logic signed [AMT_W-1:0] sel_amount;
    logic signed [AMT_W:0]   sum;
    logic signed [AMT_W-1:0] sum_sat;
    logic signed [AMT_W-1:0] new_amount;
    logic [CNT_W+ENTRIES_W-1:0] cnt_inc_ext, cnt_dec_ext, cnt_ext;

    assign accept   = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || rsp.ready;
    assign found    = |match_vec;
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign dump_last = ((CNT_W'(dump_idx_reg) + CNT_W'(1)) == count_reg);

    assign cnt_ext     = {{ENTRIES_W{1'b0}}, count_reg};
    assign cnt_inc_ext = {{ENTRIES_W{1'b0}}, count_reg + CNT_W'(1)};
    assign cnt_dec_ext = {{ENTRIES_W{1'b0}}, count_reg - CNT_W'(1)};

    // Pick the matching entry; at most one cell matches
    always_comb
    begin
        sel_key    = '0;
        sel_label  = '0;
        sel_amount = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (match_vec[i])
            begin
                sel_key    = sel_key | cell_key[i];
                sel_label  = sel_label | cell_label[i];
                sel_amount = sel_amount | cell_amount[i];
            end
        end
    end

    // Add the change to the held quantity and clamp to the 32-bit range
    always_comb
    begin
        sum = {sel_amount[AMT_W-1], sel_amount} + {amount_reg[AMT_W-1], amount_reg};
        if (sum[AMT_W] != sum[AMT_W-1])
        begin
            sum_sat = sum[AMT_W] ? AMT_MIN : AMT_MAX;
        end
        else
        begin
            sum_sat = sum[AMT_W-1:0];
        end
        new_amount = (cmd_reg == CMD_UPDATE) ? sum_sat : amount_reg;
    end

    // Drive the chain operation for this cycle
    always_comb
    begin
        ctrl.capture = accept;
        ctrl.op      = OP_NONE;
        unique case (state_reg)
            ST_EXEC:
            begin
                if (out_free)
                begin
                    priority if (cmd_reg == CMD_INSERT && !full && !found)
                        ctrl.op = OP_INSERT;
                    else if (cmd_reg == CMD_DELETE && found)
                        ctrl.op = OP_DELETE;
                    else if (cmd_reg == CMD_UPDATE && found)
                        ctrl.op = OP_UPDATE;
                    else
                        ctrl.op = OP_NONE;
                end
            end
            ST_DUMP:
            begin
                if (out_free)
                    ctrl.op = OP_ROTATE;
            end
            default:
            begin
                ctrl.op = OP_NONE;
            end
        endcase
    end

    // Chain of cells
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic                    prev_less;
        logic [KEY_W-1:0]        prev_key,    next_key;
        logic [LABEL_W-1:0]      prev_label,  next_label;
        logic signed [AMT_W-1:0] prev_amount, next_amount;

        if (i == 0)
        begin : g_first
            assign prev_less   = 1'b1;
            assign prev_key    = cell_key[i];
            assign prev_label  = cell_label[i];
            assign prev_amount = cell_amount[i];
        end
        else
        begin : g_inner
            assign prev_less   = less_vec[i-1];
            assign prev_key    = cell_key[i-1];
            assign prev_label  = cell_label[i-1];
            assign prev_amount = cell_amount[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign next_key    = cell_key[i];
            assign next_label  = cell_label[i];
            assign next_amount = cell_amount[i];
        end
        else
        begin : g_body
            assign next_key    = cell_key[i+1];
            assign next_label  = cell_label[i+1];
            assign next_amount = cell_amount[i+1];
        end

        skt_cell #(
            .LABEL_W (LABEL_W)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .cmp_key     (req.key),
            .occ         (CNT_W'(i) < count_reg),
            .tail        (CNT_W'(i + 1) == count_reg),
            .prev_less   (prev_less),
            .new_key     (key_reg),
            .new_label   (label_reg),
            .new_amount  (new_amount),
            .prev_key    (prev_key),
            .prev_label  (prev_label),
            .prev_amount (prev_amount),
            .next_key    (next_key),
            .next_label  (next_label),
            .next_amount (next_amount),
            .head_key    (cell_key[0]),
            .head_label  (cell_label[0]),
            .head_amount (cell_amount[0]),
            .key         (cell_key[i]),
            .label       (cell_label[i]),
            .amount      (cell_amount[i]),
            .match       (match_vec[i]),
            .less        (less_vec[i])
        );
    end

    // Sequencer: hold the request, execute it, build the next result
    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        key_next         = key_reg;
        label_next       = label_reg;
        amount_next      = amount_reg;
        count_next       = count_reg;
        dump_idx_next    = dump_idx_reg;
        out_valid_next   = out_valid_reg;
        out_status_next  = out_status_reg;
        out_key_next     = out_key_reg;
        out_label_next   = out_label_reg;
        out_amount_next  = out_amount_reg;
        out_entries_next = out_entries_reg;
        out_last_next    = out_last_reg;

        if (out_valid_reg && rsp.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next    = req.cmd;
                    key_next    = req.key;
                    label_next  = req.label[LABEL_W-1:0];
                    amount_next = req.amount;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    state_next       = ST_IDLE;
                    out_valid_next   = 1'b1;
                    out_last_next    = 1'b1;
                    out_status_next  = ST_NOT_FOUND;
                    out_key_next     = key_reg;
                    out_label_next   = '0;
                    out_amount_next  = '0;
                    out_entries_next = cnt_ext[ENTRIES_W-1:0];
                    unique case (cmd_reg)
                        CMD_INSERT:
                        begin
                            priority if (full)
                            begin
                                out_status_next = ST_FULL;
                            end
                            else if (found)
                            begin
                                out_status_next = ST_DUPLICATE;
                                out_key_next    = sel_key;
                                out_label_next  = sel_label;
                                out_amount_next = sel_amount;
                            end
                            else
                            begin
                                out_status_next  = ST_OK;
                                out_label_next   = label_reg;
                                out_amount_next  = amount_reg;
                                out_entries_next = cnt_inc_ext[ENTRIES_W-1:0];
                                count_next       = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_DELETE:
                        begin
                            if (found)
                            begin
                                out_status_next  = ST_OK;
                                out_key_next     = sel_key;
                                out_label_next   = sel_label;
                                out_amount_next  = sel_amount;
                                out_entries_next = cnt_dec_ext[ENTRIES_W-1:0];
                                count_next       = count_reg - CNT_W'(1);
                            end
                        end
                        CMD_UPDATE:
                        begin
                            if (found)
                            begin
                                out_status_next = ST_OK;
                                out_key_next    = sel_key;
                                out_label_next  = label_reg;
                                out_amount_next = sum_sat;
                            end
                        end
                        CMD_SEARCH:
                        begin
                            if (found)
                            begin
                                out_status_next = ST_OK;
                                out_key_next    = sel_key;
                                out_label_next  = sel_label;
                                out_amount_next = sel_amount;
                            end
                        end
                        CMD_DUMP:
                        begin
                            // Empty table reports not found; otherwise stream entries
                            if (count_reg == '0)
                            begin
                                out_key_next = '0;
                            end
                            else
                            begin
                                out_valid_next = 1'b0;
                                dump_idx_next  = '0;
                                state_next     = ST_DUMP;
                            end
                        end
                        default:
                        begin
                            out_status_next = ST_NOT_FOUND;
                        end
                    endcase
                end
            end
            ST_DUMP:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_status_next  = ST_OK;
                    out_key_next     = cell_key[0];
                    out_label_next   = cell_label[0];
                    out_amount_next  = cell_amount[0];
                    out_entries_next = cnt_ext[ENTRIES_W-1:0];
                    out_last_next    = dump_last;
                    dump_idx_next    = dump_idx_reg + IDX_W'(1);
                    if (dump_last)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold sequencer state and the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cmd_reg         <= '0;
            key_reg         <= '0;
            label_reg       <= '0;
            amount_reg      <= '0;
            count_reg       <= '0;
            dump_idx_reg    <= '0;
            out_valid_reg   <= 1'b0;
            out_status_reg  <= '0;
            out_key_reg     <= '0;
            out_label_reg   <= '0;
            out_amount_reg  <= '0;
            out_entries_reg <= '0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cmd_reg         <= cmd_next;
            key_reg         <= key_next;
            label_reg       <= label_next;
            amount_reg      <= amount_next;
            count_reg       <= count_next;
            dump_idx_reg    <= dump_idx_next;
            out_valid_reg   <= out_valid_next;
            out_status_reg  <= out_status_next;
            out_key_reg     <= out_key_next;
            out_label_reg   <= out_label_next;
            out_amount_reg  <= out_amount_next;
            out_entries_reg <= out_entries_next;
            out_last_reg    <= out_last_next;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.out_key    = out_key_reg;
    assign rsp.out_label  = LABEL_WIDTH'(out_label_reg);
    assign rsp.out_amount = out_amount_reg;
    assign rsp.entries    = out_entries_reg;
    assign rsp.last       = out_last_reg;

    // Table never holds more than DEPTH entries
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above table depth");

    // Keys are unique, so at most one cell can match
    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match_vec))
        else $error("more than one cell matches the request key");

    // A result that is not last only comes from a dump in progress
    a_partial_in_dump: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.last) |-> (state_reg == ST_DUMP))
        else $error("non-final result outside a dump");

    // A successful insert grows the table by exactly one entry
    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == OP_INSERT) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not add one entry");

    // A new request is only taken with no shifting in progress
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (ctrl.op == OP_NONE))
        else $error("request accepted while the chain moves");

endmodule
